// ===== rtl/modbus_response_crc_checker_macros.svh =====
// Assertion macros shared by the CRC checker RTL.
`ifndef MODBUS_RESPONSE_CRC_CHECKER_MACROS_SVH
`define MODBUS_RESPONSE_CRC_CHECKER_MACROS_SVH

// Same-cycle property check, sampled on the rising clock edge outside reset.
`define MRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("modbus response crc checker assertion failed");

// Next-cycle check, sampled on the rising clock edge outside reset.
`define MRC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("modbus response crc checker assertion failed");

`endif

// ===== rtl/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the response checker.
package mrc_pkg;

  localparam int unsigned MaxWords = 8;
  localparam int unsigned IdxW     = $clog2(MaxWords);
  localparam int unsigned HdrLen   = 3;
  localparam int unsigned PosW     = 5;
  localparam logic [15:0] CrcSeed  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  typedef logic [15:0] word_t;

  typedef struct packed {
    word_t [MaxWords-1:0] words;
    logic                 crc_ok;
  } mrc_result_t;

  // Reflected CRC-16 update over one byte, one bit per step.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrc_frame.sv =====
// Frame tracker: byte position, running CRC, register capture and final check.
module mrc_frame #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  output logic                res_valid_o,
  output mrc_pkg::mrc_result_t res_o
);
  import mrc_pkg::*;

  localparam int unsigned   DataEnd    = HdrLen + 2 * NUM_REGS;
  localparam logic [PosW-1:0] DataEndPos = PosW'(DataEnd);
  localparam logic [PosW-1:0] HdrPos     = PosW'(HdrLen);

  logic [15:0]               crc_q, crc_d;
  logic [PosW-1:0]           pos_q, pos_d;
  word_t [MaxWords-1:0]      words_q, words_d;
  logic [7:0]                crc_lo_q, crc_lo_d;
  logic                      done_q, done_d;

  logic [15:0]               cur_crc;
  logic [PosW-1:0]           cur_pos;
  logic [PosW-1:0]           off;
  logic [IdxW-1:0]           idx;
  logic                      active;
  logic                      ok;

  // A start byte restarts the frame as byte zero; other bytes after a frame are dropped.
  always_comb begin
    cur_crc = frame_start_i ? CrcSeed : crc_q;
    cur_pos = frame_start_i ? '0 : pos_q;
    active  = beat_i && (frame_start_i || !done_q);
    off     = cur_pos - HdrPos;
    idx     = off[IdxW:1];
    ok      = (crc_lo_q == cur_crc[7:0]) && (rx_byte_i == cur_crc[15:8]);

    crc_d       = crc_q;
    pos_d       = pos_q;
    words_d     = words_q;
    crc_lo_d    = crc_lo_q;
    done_d      = done_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (active) begin
      crc_d    = cur_crc;
      words_d  = frame_start_i ? '0 : words_q;
      crc_lo_d = frame_start_i ? 8'h00 : crc_lo_q;
      done_d   = 1'b0;
      if (cur_pos < DataEndPos) begin
        // Header and data bytes feed the CRC; data bytes land big-endian.
        crc_d = crc16_byte(cur_crc, rx_byte_i);
        if (cur_pos >= HdrPos) begin
          if (!off[0]) begin
            words_d[idx][15:8] = rx_byte_i;
          end else begin
            words_d[idx][7:0] = rx_byte_i;
          end
        end
        pos_d = cur_pos + 1'b1;
      end else if (cur_pos == DataEndPos) begin
        crc_lo_d = rx_byte_i;
        pos_d    = cur_pos + 1'b1;
      end else begin
        // Last byte: compare and release the words only on a match.
        res_valid_o  = 1'b1;
        res_o.crc_ok = ok;
        for (int k = 0; k < MaxWords; k++) begin
          if (ok && (k < NUM_REGS)) begin
            res_o.words[k] = words_q[k];
          end
        end
        done_d = 1'b1;
        pos_d  = '0;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcSeed;
      pos_q    <= '0;
      words_q  <= '0;
      crc_lo_q <= '0;
      done_q   <= 1'b1;
    end else begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      words_q  <= words_d;
      crc_lo_q <= crc_lo_d;
      done_q   <= done_d;
    end
  end

endmodule

// ===== rtl/mrc_out_reg.sv =====
// Output register holding one result beat until the consumer takes it.
module mrc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mrc_pkg::mrc_result_t res_i,
  input  logic                 out_ready_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  output mrc_pkg::mrc_result_t res_o
);
  import mrc_pkg::*;

  logic        valid_q, valid_d;
  mrc_result_t res_q;

  // The slot is free when empty or when its beat leaves this cycle.
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/modbus_response_crc_checker.sv =====
// A result beat is registered and appears in the cycle after the last CRC byte is accepted.
// Throughput: one byte per cycle; the CRC-16 byte update is fully unrolled.
// The only stall comes from a held result in the output register.
// Reset: CRC seed, position zero, words cleared, and waiting for a frame start.
`include "modbus_response_crc_checker_macros.svh"

// Top level of the Modbus RTU response CRC checker.
module modbus_response_crc_checker #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] word_0_o,
  output logic [15:0] word_1_o,
  output logic [15:0] word_2_o,
  output logic [15:0] word_3_o,
  output logic [15:0] word_4_o,
  output logic [15:0] word_5_o,
  output logic [15:0] word_6_o,
  output logic [15:0] word_7_o,
  output logic        crc_ok_o
);
  import mrc_pkg::*;

  logic        beat;
  logic        res_valid;
  mrc_result_t res_new;
  mrc_result_t res_out;

  assign beat = in_valid_i && in_ready_o;

  mrc_frame #(
    .NUM_REGS(NUM_REGS)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .res_valid_o  (res_valid),
    .res_o        (res_new)
  );

  mrc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res_new),
    .out_ready_i(out_ready_i),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  // Fan the result out to its ports.
  assign word_0_o = res_out.words[0];
  assign word_1_o = res_out.words[1];
  assign word_2_o = res_out.words[2];
  assign word_3_o = res_out.words[3];
  assign word_4_o = res_out.words[4];
  assign word_5_o = res_out.words[5];
  assign word_6_o = res_out.words[6];
  assign word_7_o = res_out.words[7];
  assign crc_ok_o = res_out.crc_ok;

  // A failed check never leaks captured data.
  `MRC_ASSERT(a_fail_zero, (out_valid_o && !crc_ok_o) |-> (res_out.words == '0))
  // Registers beyond the configured count read as zero in a valid result; this checks word 7.
  `MRC_ASSERT(a_unused_zero, (out_valid_o && (NUM_REGS < 8)) |-> (word_7_o == 16'h0000))
  // A new result beat only follows an accepted input byte.
  `MRC_ASSERT(a_result_cause, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))

endmodule
